// ===== rtl/glt_pkg.sv =====
package glt_pkg;

	localparam int MAX_SIZE_XZ_DEF = 32;
	localparam int MAX_SIZE_Y_DEF = 256;

	localparam int SZ_W = 11;
	localparam int CFG_W = 9;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_SMOOTH = 2'd1;
	localparam logic [1:0] ACT_FACE = 2'd2;

	localparam logic [1:0] CFG_SIZE_X = 2'd0;
	localparam logic [1:0] CFG_SIZE_Y = 2'd1;
	localparam logic [1:0] CFG_SIZE_Z = 2'd2;

	localparam logic signed [15:0] SHIFT_NUM = 16'sd29491;
	localparam logic [15:0] RECIP_15 = 16'd34953;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_FACE,
		CMD_SMOOTH
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic [7:0] ix;
		logic [9:0] iy;
		logic [7:0] iz;
		logic [7:0] fx;
		logic [7:0] fy;
		logic [7:0] fz;
		logic [7:0] level;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_FACE_RD,
		BK_FACE_WAIT,
		BK_SMOOTH,
		BK_DIV,
		BK_DONE
	} back_state_t;

	function automatic logic [SZ_W-1:0] eff_size(logic [CFG_W-1:0] r, int maxv);
		logic [SZ_W-1:0] s;
		s = SZ_W'(r);
		if (s < SZ_W'(2)) begin
			s = SZ_W'(2);
		end else if (s > SZ_W'(maxv)) begin
			s = SZ_W'(maxv);
		end
		return s;
	endfunction

	// Returns the clamped Q8 point: cell index in [17:8], weight in [7:0].
	function automatic logic [17:0] smooth_point(logic signed [17:0] pos,
			logic signed [31:0] prod, logic [SZ_W-1:0] size);
		logic signed [31:0] r;
		logic signed [18:0] s;
		logic [SZ_W-1:0] top;
		logic [17:0] hi;
		logic [17:0] c;
		r = prod + 32'sd2097152;
		s = $signed({pos[17], pos}) + $signed({{9{r[31]}}, r[31:22]});
		top = size - SZ_W'(2);
		hi = {top[9:0], 8'hFF};
		if (s[18]) begin
			c = '0;
		end else if (s[17:0] > hi) begin
			c = hi;
		end else begin
			c = s[17:0];
		end
		return c;
	endfunction

	function automatic logic [9:0] face_coord(logic signed [17:0] pos, logic [SZ_W-1:0] size);
		logic [SZ_W-1:0] m;
		logic [9:0] c;
		m = size - SZ_W'(1);
		if (pos[17]) begin
			c = '0;
		end else if (SZ_W'(pos[16:8]) > m) begin
			c = m[9:0];
		end else begin
			c = {1'b0, pos[16:8]};
		end
		return c;
	endfunction

	function automatic logic in_grid(logic signed [17:0] pos, logic [SZ_W-1:0] size);
		return !pos[17] && (SZ_W'(pos[16:8]) < size);
	endfunction

	function automatic logic [12:0] face_level(logic [3:0] lv);
		logic [12:0] v;
		case (lv)
			4'd0: v = 13'd0;
			4'd1: v = 13'd273;
			4'd2: v = 13'd546;
			4'd3: v = 13'd819;
			4'd4: v = 13'd1092;
			4'd5: v = 13'd1365;
			4'd6: v = 13'd1638;
			4'd7: v = 13'd1911;
			4'd8: v = 13'd2185;
			4'd9: v = 13'd2458;
			4'd10: v = 13'd2731;
			4'd11: v = 13'd3004;
			4'd12: v = 13'd3277;
			4'd13: v = 13'd3550;
			4'd14: v = 13'd3823;
			4'd15: v = 13'd4096;
			default: v = 13'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/glt_if.sv =====
interface glt_in_if;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic signed [17:0] pos_x;
	logic signed [17:0] pos_y;
	logic signed [17:0] pos_z;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic [3:0] sun_level;
	logic [3:0] block_level;

	modport source (output valid, action, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
		sun_level, block_level, input ready);
	modport sink (input valid, action, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
		sun_level, block_level, output ready);
endinterface

interface glt_out_if;
	logic valid;
	logic ready;
	logic [12:0] sun_light;
	logic [12:0] block_light;

	modport source (output valid, sun_light, block_light, input ready);
	modport sink (input valid, sun_light, block_light, output ready);
endinterface

// ===== rtl/glt_fifo.sv =====
module glt_fifo #(
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input glt_pkg::cmd_t push_data,
	input logic pop,
	output glt_pkg::cmd_t head,
	output logic empty,
	output logic full
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	glt_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == (PW+1)'(DEPTH));
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop && !empty) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
		end
	end
endmodule

// ===== rtl/glt_front.sv =====
module glt_front #(
	parameter int MAX_SIZE_XZ = glt_pkg::MAX_SIZE_XZ_DEF,
	parameter int MAX_SIZE_Y = glt_pkg::MAX_SIZE_Y_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [glt_pkg::CFG_W-1:0] cfg_data,
	glt_in_if.sink in_ch,
	output logic push,
	output glt_pkg::cmd_t cmd,
	input logic full
);
	logic [5:0] size_x_q;
	logic [8:0] size_y_q;
	logic [5:0] size_z_q;

	logic v_s1;
	logic [1:0] act_s1;
	logic signed [17:0] px_s1, py_s1, pz_s1;
	logic signed [31:0] nx_s1, ny_s1, nz_s1;
	logic [7:0] lvl_s1;

	logic [glt_pkg::SZ_W-1:0] sx, sy, sz;
	logic [17:0] cx, cy, cz;
	logic [9:0] fcx, fcy, fcz;
	logic need;
	logic adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= 6'd17;
			size_y_q <= 9'd256;
			size_z_q <= 6'd17;
		end else if (cfg_we) begin
			case (cfg_idx)
				glt_pkg::CFG_SIZE_X: size_x_q <= cfg_data[5:0];
				glt_pkg::CFG_SIZE_Y: size_y_q <= cfg_data;
				glt_pkg::CFG_SIZE_Z: size_z_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign sx = glt_pkg::eff_size({3'd0, size_x_q}, MAX_SIZE_XZ);
	assign sy = glt_pkg::eff_size(size_y_q, MAX_SIZE_Y);
	assign sz = glt_pkg::eff_size({3'd0, size_z_q}, MAX_SIZE_XZ);

	always_comb begin
		cx = glt_pkg::smooth_point(px_s1, nx_s1, sx);
		cy = glt_pkg::smooth_point(py_s1, ny_s1, sy);
		cz = glt_pkg::smooth_point(pz_s1, nz_s1, sz);
		fcx = glt_pkg::face_coord(px_s1, sx);
		fcy = glt_pkg::face_coord(py_s1, sy);
		fcz = glt_pkg::face_coord(pz_s1, sz);
		cmd.level = lvl_s1;
		cmd.fx = cx[7:0];
		cmd.fy = cy[7:0];
		cmd.fz = cz[7:0];
		case (act_s1)
			glt_pkg::ACT_WRITE: begin
				need = glt_pkg::in_grid(px_s1, sx) && glt_pkg::in_grid(py_s1, sy)
					&& glt_pkg::in_grid(pz_s1, sz);
				cmd.op = glt_pkg::CMD_WRITE;
				cmd.ix = px_s1[15:8];
				cmd.iy = py_s1[17:8];
				cmd.iz = pz_s1[15:8];
			end
			glt_pkg::ACT_FACE: begin
				need = 1'b1;
				cmd.op = glt_pkg::CMD_FACE;
				cmd.ix = fcx[7:0];
				cmd.iy = fcy;
				cmd.iz = fcz[7:0];
			end
			glt_pkg::ACT_SMOOTH: begin
				need = 1'b1;
				cmd.op = glt_pkg::CMD_SMOOTH;
				cmd.ix = cx[15:8];
				cmd.iy = cy[17:8];
				cmd.iz = cz[15:8];
			end
			default: begin
				need = 1'b0;
				cmd.op = glt_pkg::CMD_WRITE;
				cmd.ix = '0;
				cmd.iy = '0;
				cmd.iz = '0;
			end
		endcase
	end

	assign adv = v_s1 && (!need || !full);
	assign push = v_s1 && need && !full;
	assign in_ch.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			act_s1 <= in_ch.action;
			px_s1 <= in_ch.pos_x;
			py_s1 <= in_ch.pos_y;
			pz_s1 <= in_ch.pos_z;
			nx_s1 <= in_ch.normal_x * glt_pkg::SHIFT_NUM;
			ny_s1 <= in_ch.normal_y * glt_pkg::SHIFT_NUM;
			nz_s1 <= in_ch.normal_z * glt_pkg::SHIFT_NUM;
			lvl_s1 <= {in_ch.sun_level, in_ch.block_level};
		end
	end
endmodule

// ===== rtl/glt_back.sv =====
module glt_back #(
	parameter int MAX_SIZE_XZ = glt_pkg::MAX_SIZE_XZ_DEF,
	parameter int MAX_SIZE_Y = glt_pkg::MAX_SIZE_Y_DEF
) (
	input logic clk,
	input logic arst_n,
	input glt_pkg::cmd_t head,
	input logic empty,
	output logic pop,
	glt_out_if.source out_ch
);
	localparam int DEPTH = MAX_SIZE_XZ * MAX_SIZE_XZ * MAX_SIZE_Y;
	localparam int AW = $clog2(DEPTH);

	glt_pkg::back_state_t state_q, state_d;
	glt_pkg::cmd_t cmd_q;
	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;
	logic [7:0] lvl_s2;
	logic [3:0] cnt_q;
	logic v1_s1, v2_s2;
	logic [16:0] wxy_s1;
	logic [8:0] wz_s1;
	logic [24:0] w_s2;
	logic [27:0] acc_s_q, acc_b_q;
	logic [31:0] qs_q, qb_q;
	logic out_v_q;
	logic [12:0] sun_q, blk_q;

	logic mem_we, rd_en, issue, load_out;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [2:0] k;
	logic [8:0] wx, wy, wz;
	logic [27:0] ts_sum, tb_sum;
	logic [12:0] res_s, res_b;

	function automatic logic [AW-1:0] addr_of(logic [7:0] x, logic [9:0] y, logic [7:0] z);
		return AW'(y) * AW'(MAX_SIZE_XZ * MAX_SIZE_XZ) + AW'(z) * AW'(MAX_SIZE_XZ) + AW'(x);
	endfunction

	assign k = cnt_q[2:0];
	assign wx = k[0] ? {1'b0, cmd_q.fx} : 9'd256 - {1'b0, cmd_q.fx};
	assign wy = k[1] ? {1'b0, cmd_q.fy} : 9'd256 - {1'b0, cmd_q.fy};
	assign wz = k[2] ? {1'b0, cmd_q.fz} : 9'd256 - {1'b0, cmd_q.fz};
	assign wr_addr = addr_of(head.ix, head.iy, head.iz);
	assign rd_addr = (state_q == glt_pkg::BK_FACE_RD) ? addr_of(cmd_q.ix, cmd_q.iy, cmd_q.iz)
		: addr_of(cmd_q.ix + 8'(k[0]), cmd_q.iy + 10'(k[1]), cmd_q.iz + 8'(k[2]));

	always_comb begin
		state_d = state_q;
		case (state_q)
			glt_pkg::BK_IDLE: begin
				if (!empty) begin
					case (head.op)
						glt_pkg::CMD_FACE: state_d = glt_pkg::BK_FACE_RD;
						glt_pkg::CMD_SMOOTH: state_d = glt_pkg::BK_SMOOTH;
						default: state_d = glt_pkg::BK_IDLE;
					endcase
				end
			end
			glt_pkg::BK_FACE_RD: state_d = glt_pkg::BK_FACE_WAIT;
			glt_pkg::BK_FACE_WAIT: state_d = glt_pkg::BK_DONE;
			glt_pkg::BK_SMOOTH: begin
				if (cnt_q == 4'd9) begin
					state_d = glt_pkg::BK_DIV;
				end
			end
			glt_pkg::BK_DIV: state_d = glt_pkg::BK_DONE;
			glt_pkg::BK_DONE: begin
				if (!out_v_q || out_ch.ready) begin
					state_d = glt_pkg::BK_IDLE;
				end
			end
			default: state_d = glt_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		mem_we = 1'b0;
		rd_en = 1'b0;
		issue = 1'b0;
		load_out = 1'b0;
		case (state_q)
			glt_pkg::BK_IDLE: begin
				pop = !empty;
				mem_we = !empty && (head.op == glt_pkg::CMD_WRITE);
			end
			glt_pkg::BK_FACE_RD: rd_en = 1'b1;
			glt_pkg::BK_SMOOTH: begin
				issue = !cnt_q[3];
				rd_en = !cnt_q[3];
			end
			glt_pkg::BK_DONE: load_out = !out_v_q || out_ch.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= head.level;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign ts_sum = acc_s_q + 28'd30720;
	assign tb_sum = acc_b_q + 28'd30720;

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		wxy_s1 <= wx * wy;
		wz_s1 <= wz;
		w_s2 <= 25'(wxy_s1) * 25'(wz_s1);
		if (pop) begin
			acc_s_q <= '0;
			acc_b_q <= '0;
		end else if (v2_s2) begin
			acc_s_q <= acc_s_q + 28'(w_s2) * 28'(lvl_s2[7:4]);
			acc_b_q <= acc_b_q + 28'(w_s2) * 28'(lvl_s2[3:0]);
		end
		if (state_q == glt_pkg::BK_DIV) begin
			qs_q <= ts_sum[27:12] * glt_pkg::RECIP_15;
			qb_q <= tb_sum[27:12] * glt_pkg::RECIP_15;
		end
	end

	always_ff @(posedge clk) begin
		lvl_s2 <= rdata_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= glt_pkg::BK_IDLE;
			cnt_q <= '0;
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
		end else begin
			state_q <= state_d;
			v1_s1 <= issue;
			v2_s2 <= v1_s1;
			if (pop) begin
				cnt_q <= '0;
			end else if (state_q == glt_pkg::BK_SMOOTH) begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	always_comb begin
		if (cmd_q.op == glt_pkg::CMD_FACE) begin
			res_s = glt_pkg::face_level(rdata_q[7:4]);
			res_b = glt_pkg::face_level(rdata_q[3:0]);
		end else begin
			res_s = qs_q[31:19];
			res_b = qb_q[31:19];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			sun_q <= res_s;
			blk_q <= res_b;
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.sun_light = sun_q;
	assign out_ch.block_light = blk_q;
endmodule

// ===== rtl/grid_light_trilinear_sampler_core.sv =====
// A face or smooth sample is worked to its end by the back end before it takes the next
// command from the FIFO; a cell write reaches the store through the front stage and the FIFO.
// Writes retire one per cycle while the back end is idle and the FIFO holds a command.
// Reset clears control state and sets the grid to 17 x 256 x 17; the cell store is not
// cleared and a cell holds no defined value until it is written.
module grid_light_trilinear_sampler_core #(
	parameter int MAX_SIZE_XZ = glt_pkg::MAX_SIZE_XZ_DEF,
	parameter int MAX_SIZE_Y = glt_pkg::MAX_SIZE_Y_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [glt_pkg::CFG_W-1:0] cfg_data,
	glt_in_if.sink in_ch,
	glt_out_if.source out_ch
);
	glt_pkg::cmd_t push_cmd, head;
	logic push, pop, empty, full;

	glt_front #(.MAX_SIZE_XZ(MAX_SIZE_XZ), .MAX_SIZE_Y(MAX_SIZE_Y)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_ch(in_ch), .push(push), .cmd(push_cmd), .full(full)
	);

	glt_fifo #(.DEPTH(4)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_cmd), .pop(pop),
		.head(head), .empty(empty), .full(full)
	);

	glt_back #(.MAX_SIZE_XZ(MAX_SIZE_XZ), .MAX_SIZE_Y(MAX_SIZE_Y)) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .empty(empty), .pop(pop), .out_ch(out_ch)
	);
endmodule
